// ===== rtl/core/twc_pkg.sv =====
// Shared types and constants of the textured wall column block.
// Used by twc_front, twc_back and textured_wall_column.
package twc_pkg;

   localparam int SCREEN_ROWS_DEF = 1024;
   localparam int TEX_WIDTH = 64;
   localparam int TEX_HEIGHT = 64;
   localparam int TEX_COUNT = 4;
   localparam int STORE_DEPTH = 16384;
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int COL_W = 6;
   localparam int ROW_W = 6;
   localparam int TNUM_W = $clog2(TEX_COUNT);
   localparam int TEX_ROW_W = $clog2(TEX_HEIGHT);
   localparam int TEX_NUM_W = $clog2(TEX_HEIGHT) + 17;

   localparam logic [1:0] MODE_SETUP = 2'd0;
   localparam logic [1:0] MODE_PIXEL = 2'd1;
   localparam logic [1:0] MODE_TEXEL = 2'd2;

   localparam logic [7:0] SUB_X_NEG = 8'd49;
   localparam logic [7:0] SUB_Y_POS = 8'd48;
   localparam logic [7:0] SUB_X_POS = 8'd47;
   localparam logic [7:0] SUB_Y_NEG = 8'd46;
   localparam logic [23:0] SHADE_MASK = 24'h7F7F7F;

   typedef struct packed {
      logic [1:0]  mode;
      logic        hit_side;
      logic [31:0] side_dist;
      logic [31:0] delta_dist;
      logic [23:0] dir_along;
      logic [23:0] dir_across;
      logic [23:0] pos_along;
      logic [7:0]  wall_code;
      logic [13:0] texel_index;
      logic [23:0] texel_color;
   } item_type;

endpackage

// ===== rtl/core/twc_front.sv =====
// Front part: accepts request beats, drops unused modes and queues the rest.
// Depends on twc_pkg.
module twc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  twc_pkg::item_type  req_item,
   output logic               item_valid,
   input  logic               item_pop,
   output twc_pkg::item_type  item
);

   twc_pkg::item_type entries_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;
   logic       pop;
   logic       mode_used;

   assign mode_used = (req_item.mode == twc_pkg::MODE_SETUP) ||
                      (req_item.mode == twc_pkg::MODE_PIXEL) ||
                      (req_item.mode == twc_pkg::MODE_TEXEL);
   assign req_ready = (count_ff != 2'd2);
   assign push = req_valid && req_ready && mode_used;
   assign item_valid = (count_ff != 2'd0);
   assign pop = item_valid && item_pop;
   assign item = entries_ff[rd_ptr_ff];
   assign count_in = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> !req_ready)
      else $error("queue full but ready high");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0) |-> !item_valid)
      else $error("empty queue shows an item");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue count lost a push");

endmodule

// ===== rtl/core/twc_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Does not depend on twc_pkg; its width comes from its own parameter.
module twc_div #(
   parameter int NUM_W = 27
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [31:0]      den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [32:0]      rem_ff;
   logic [NUM_W-1:0] quot_ff;
   logic [31:0]      den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [32:0]      trial;
   logic             take;

   assign trial = {rem_ff[31:0], quot_ff[NUM_W-1]};
   assign take = (trial >= {1'b0, den_ff});
   assign done = done_ff;
   assign quot = quot_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= 33'd0;
         quot_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= take ? (trial - {1'b0, den_ff}) : trial;
         quot_ff <= {quot_ff[NUM_W-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while busy");
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff == CNT_W'(1)) |=> done_ff)
      else $error("divider missed its done");
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0))
      else $error("divider count ran out while busy");

endmodule

// ===== rtl/core/twc_back.sv =====
// Back part: ray setup sequencer, texture store and pixel output register.
// Depends on twc_pkg and twc_div.
module twc_back #(
   parameter int SCREEN_ROWS = twc_pkg::SCREEN_ROWS_DEF,
   parameter int NUM_W = 27
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  twc_pkg::item_type item,
   output logic              item_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [9:0]        rsp_pixel_row,
   output logic [23:0]       rsp_pixel_color,
   output logic              rsp_last_row
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_D1GO  = 4'd1;
   localparam logic [3:0] S_D1WT  = 4'd2;
   localparam logic [3:0] S_GEO   = 4'd3;
   localparam logic [3:0] S_D2GO  = 4'd4;
   localparam logic [3:0] S_D2WT  = 4'd5;
   localparam logic [3:0] S_POS   = 4'd6;
   localparam logic [3:0] S_PIX   = 4'd7;

   localparam logic [NUM_W-1:0] HALF_ROWS = NUM_W'(SCREEN_ROWS / 2);
   localparam logic [NUM_W-1:0] LOW_SPAN = NUM_W'(SCREEN_ROWS - 1 - SCREEN_ROWS / 2);
   localparam logic [NUM_W-1:0] ROWS_NUM = NUM_W'(SCREEN_ROWS * 65536);
   localparam logic [NUM_W-1:0] TEX_NUM = NUM_W'(twc_pkg::TEX_HEIGHT * 65536);
   localparam int CP_W = 32 + $clog2(twc_pkg::TEX_WIDTH + 1);

   logic [3:0]  state_ff;
   logic        side_ff;
   logic [23:0] along_ff;
   logic [23:0] across_ff;
   logic [23:0] pos_ff;
   logic [7:0]  code_ff;
   logic [31:0] dist_ff;
   logic [NUM_W-1:0] lineh_ff;
   logic [NUM_W-1:0] offset_ff;
   logic [9:0]  start_ff;
   logic [9:0]  stop_ff;
   logic [31:0] prod_ff;
   logic [31:0] step_ff;

   logic [9:0]  current_row_ff;
   logic [9:0]  end_row_ff;
   logic        span_active_ff;
   logic [31:0] texture_pos_ff;
   logic [31:0] texture_step_ff;
   logic [5:0]  texture_column_ff;
   logic [1:0]  texture_number_ff;
   logic        shade_flag_ff;

   logic [23:0] store [twc_pkg::STORE_DEPTH];
   logic [23:0] rd_data_ff;
   logic [9:0]  pend_row_ff;
   logic        pend_last_ff;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [9:0]  rsp_row_ff;
   logic [23:0] rsp_color_ff;
   logic        rsp_last_ff;

   logic             div_start;
   logic [NUM_W-1:0] div_num;
   logic [31:0]      div_den;
   logic             div_done;
   logic [NUM_W-1:0] div_quot;

   logic [NUM_W-2:0] half;
   logic [NUM_W-1:0] half_w;
   logic [23:0] mag;
   logic [55:0] prod_full;
   logic [31:0] frac;
   logic [CP_W-1:0] col_full;
   logic [5:0]  col;
   logic        across_neg;
   logic        across_pos;
   logic [7:0]  sub;
   logic [NUM_W+31:0] pos_full;
   logic [twc_pkg::ADDR_W-1:0] rd_addr;
   logic        store_we;
   logic        rd_en;
   logic        out_free;
   logic [23:0] shaded;

   twc_div #(.NUM_W(NUM_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign div_start = (state_ff == S_D1GO) || (state_ff == S_D2GO);
   assign div_num = (state_ff == S_D1GO) ? ROWS_NUM : TEX_NUM;
   assign div_den = (state_ff == S_D1GO) ? dist_ff : 32'(lineh_ff);

   assign item_pop = item_valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = ((state_ff == S_PIX) && out_free) || (rsp_valid_ff && !rsp_ready);

   assign half = lineh_ff[NUM_W-1:1];
   assign half_w = {1'b0, half};
   assign across_neg = across_ff[23];
   assign across_pos = !across_ff[23] && (across_ff != 24'd0);
   assign mag = along_ff[23] ? (~along_ff + 24'd1) : along_ff;
   assign prod_full = {24'd0, dist_ff} * {32'd0, mag};

   always_comb begin
      case ({side_ff, across_neg})
         2'b01:   sub = twc_pkg::SUB_X_NEG;
         2'b00:   sub = twc_pkg::SUB_X_POS;
         2'b10:   sub = twc_pkg::SUB_Y_POS;
         default: sub = twc_pkg::SUB_Y_NEG;
      endcase
   end

   assign frac = along_ff[23] ? ({pos_ff[15:0], 16'd0} - prod_ff)
                              : ({pos_ff[15:0], 16'd0} + prod_ff);
   assign col_full = CP_W'(frac) * CP_W'(twc_pkg::TEX_WIDTH);
   assign col = 6'(col_full[CP_W-1:32]);
   assign pos_full = (NUM_W+32)'(offset_ff) * (NUM_W+32)'(step_ff);

   assign rd_en = item_pop && (item.mode == twc_pkg::MODE_PIXEL) && span_active_ff;
   assign store_we = item_pop && (item.mode == twc_pkg::MODE_TEXEL);
   assign rd_addr = {texture_number_ff,
                     twc_pkg::ROW_W'(texture_pos_ff[16 +: twc_pkg::TEX_ROW_W]),
                     texture_column_ff};
   assign shaded = shade_flag_ff ? ((rd_data_ff >> 1) & twc_pkg::SHADE_MASK) : rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_we) begin
         store[item.texel_index] <= item.texel_color;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop && item.mode == twc_pkg::MODE_SETUP) begin
         side_ff <= item.hit_side;
         along_ff <= item.dir_along;
         across_ff <= item.dir_across;
         pos_ff <= item.pos_along;
         code_ff <= item.wall_code;
         dist_ff <= (item.side_dist > item.delta_dist) ?
                    (item.side_dist - item.delta_dist) : 32'd1;
      end
      if (state_ff == S_D1WT && div_done) begin
         lineh_ff <= (div_quot == '0) ? NUM_W'(1) : div_quot;
      end
      if (state_ff == S_GEO) begin
         start_ff <= (half_w >= HALF_ROWS) ? 10'd0 : 10'(HALF_ROWS - half_w);
         stop_ff <= (half_w >= LOW_SPAN) ? 10'(SCREEN_ROWS - 1) : 10'(HALF_ROWS + half_w);
         offset_ff <= (half_w > HALF_ROWS) ? (half_w - HALF_ROWS) : '0;
         prod_ff <= prod_full[31:0];
      end
      if (state_ff == S_D2WT && div_done) begin
         step_ff <= 32'(div_quot);
      end
      if (rd_en) begin
         pend_row_ff <= current_row_ff;
         pend_last_ff <= (current_row_ff == end_row_ff);
      end
      if (state_ff == S_PIX && out_free) begin
         rsp_row_ff <= pend_row_ff;
         rsp_color_ff <= shaded;
         rsp_last_ff <= pend_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         current_row_ff <= 10'd0;
         end_row_ff <= 10'd0;
         span_active_ff <= 1'b0;
         texture_pos_ff <= 32'd0;
         texture_step_ff <= 32'd0;
         texture_column_ff <= 6'd0;
         texture_number_ff <= 2'd0;
         shade_flag_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            S_IDLE: begin
               if (item_pop && item.mode == twc_pkg::MODE_SETUP) state_ff <= S_D1GO;
               if (rd_en) begin
                  state_ff <= S_PIX;
                  texture_pos_ff <= texture_pos_ff + texture_step_ff;
                  if (current_row_ff == end_row_ff) span_active_ff <= 1'b0;
                  else current_row_ff <= current_row_ff + 10'd1;
               end
            end
            S_D1GO: state_ff <= S_D1WT;
            S_D1WT: if (div_done) state_ff <= S_GEO;
            S_GEO: begin
               if (across_ff != 24'd0) texture_number_ff <= code_ff[1:0] - sub[1:0];
               state_ff <= S_D2GO;
            end
            S_D2GO: begin
               texture_column_ff <= (side_ff ? across_neg : across_pos) ?
                                    6'(twc_pkg::TEX_WIDTH - 1) - col : col;
               state_ff <= S_D2WT;
            end
            S_D2WT: if (div_done) state_ff <= S_POS;
            S_POS: begin
               texture_step_ff <= step_ff;
               texture_pos_ff <= pos_full[31:0];
               shade_flag_ff <= side_ff;
               current_row_ff <= start_ff;
               end_row_ff <= stop_ff;
               span_active_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_PIX: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_row = rsp_row_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_last_row = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      span_active_ff |-> (current_row_ff <= end_row_ff))
      else $error("current row passed the end row");
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_D1WT || state_ff == S_D2WT))
      else $error("divider finished outside a wait state");
   assert property (@(posedge clock) disable iff (reset)
      rd_en |=> (state_ff == S_PIX))
      else $error("pixel read without output step");

endmodule

// ===== rtl/core/textured_wall_column.sv =====
// Top level of the textured wall column block.
// Depends on twc_pkg, twc_front, twc_div and twc_back.
//
//   channel   direction  beat content
//   req_      in         mode, ray hit fields, texel write fields
//   rsp_      out        pixel row, pixel color, last row flag
//
// A texel write goes straight into the texture store; a pixel beat passes
// through the texture memory read port and then the output register, and the
// back part takes no new beat until the pixel has entered that register.
// A ray setup runs the serial divider twice: line height, then texture step.
// Reset is synchronous; the texture store is not cleared and needs no sweep.
// A two-beat queue lets requests enter while a result waits on rsp_ready.
module textured_wall_column #(
   parameter int SCREEN_ROWS = twc_pkg::SCREEN_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic        req_hit_side,
   input  logic [31:0] req_side_dist,
   input  logic [31:0] req_delta_dist,
   input  logic signed [23:0] req_dir_along,
   input  logic signed [23:0] req_dir_across,
   input  logic [23:0] req_pos_along,
   input  logic [7:0]  req_wall_code,
   input  logic [13:0] req_texel_index,
   input  logic [23:0] req_texel_color,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_pixel_row,
   output logic [23:0] rsp_pixel_color,
   output logic        rsp_last_row
);

   localparam int ROWS_NUM_W = $clog2(SCREEN_ROWS) + 17;
   localparam int NUM_W = (ROWS_NUM_W > twc_pkg::TEX_NUM_W) ? ROWS_NUM_W
                                                          : twc_pkg::TEX_NUM_W;

   twc_pkg::item_type req_item;
   twc_pkg::item_type item;
   logic item_valid;
   logic item_pop;

   assign req_item = '{mode: req_mode, hit_side: req_hit_side,
                       side_dist: req_side_dist, delta_dist: req_delta_dist,
                       dir_along: req_dir_along, dir_across: req_dir_across,
                       pos_along: req_pos_along, wall_code: req_wall_code,
                       texel_index: req_texel_index, texel_color: req_texel_color};

   twc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item)
   );

   twc_back #(.SCREEN_ROWS(SCREEN_ROWS), .NUM_W(NUM_W)) u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_row   (rsp_pixel_row),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_row    (rsp_last_row)
   );

endmodule
